### rtl/dlph_pkg.sv
package dlph_pkg;

    localparam int W = 32;
    localparam int CNT_W = $clog2(W + 1);
    localparam logic [W:0] MOD_WORD = (W + 1)'(1) << W;

    typedef enum logic {
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    typedef struct packed {
        logic           start;
        t_alu_op        op;
        logic [W-1:0]   a;
        logic [W-1:0]   b;
        logic [W:0]     m;
    } t_alu_req;

    typedef struct packed {
        logic           done;
        logic [W-1:0]   res;
        logic [W-1:0]   rem;
    } t_alu_rsp;

    typedef struct packed {
        logic           valid;
        logic [W-1:0]   exponent;
        logic           found;
    } t_result;

    typedef enum logic [5:0] {
        S_IDLE, S_CHK, S_RA, S_RB, S_INV, S_INV_R, S_FT, S_FT2, S_FACT, S_FD, S_FQ,
        S_SQ, S_SG, S_SG_R, S_DK, S_DK1, S_DK2, S_DK3, S_DK4, S_SR, S_SM, S_SC,
        S_DG, S_DG2, S_DG3, S_CG, S_CG2, S_CG3, S_CG4, S_CG5, S_CG6, S_DONE,
        S_PW_LOOP, S_PW_MULR, S_PW_SQR
    } t_state;

endpackage

### rtl/dlph_alu.sv
module dlph_alu
    import dlph_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_alu_op          r_op, n_op;
    logic [W-1:0]     r_a, n_a;
    logic [W:0]       r_m, n_m;
    logic [W:0]       r_acc, n_acc;
    logic [W-1:0]     r_mc, n_mc;

    logic [W+2:0] t0, t1, t2, m_ext;
    logic [W:0]   sh;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_op   = r_op;
        n_a    = r_a;
        n_m    = r_m;
        n_acc  = r_acc;
        n_mc   = r_mc;
        m_ext  = (W + 3)'(r_m);
        t0     = {1'b0, r_acc, 1'b0} + (r_mc[W-1] ? (W + 3)'(r_a) : '0);
        t1     = (t0 >= m_ext) ? t0 - m_ext : t0;
        t2     = (t1 >= m_ext) ? t1 - m_ext : t1;
        sh     = {r_acc[W-1:0], r_mc[W-1]};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(W);
            n_op   = i_req.op;
            n_m    = i_req.m;
            n_acc  = '0;
            if (i_req.op == ALU_MUL) begin
                n_a  = i_req.a;
                n_mc = i_req.b;
            end else begin
                n_a  = i_req.b;
                n_mc = i_req.a;
            end
        end else if (r_busy) begin
            if (r_op == ALU_MUL) begin
                n_acc = t2[W:0];
                n_mc  = {r_mc[W-2:0], 1'b0};
            end else begin
                if (sh >= {1'b0, r_a}) begin
                    n_acc = sh - {1'b0, r_a};
                    n_mc  = {r_mc[W-2:0], 1'b1};
                end else begin
                    n_acc = sh;
                    n_mc  = {r_mc[W-2:0], 1'b0};
                end
            end
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_op  <= n_op;
        r_a   <= n_a;
        r_m   <= n_m;
        r_acc <= n_acc;
        r_mc  <= n_mc;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = (r_op == ALU_MUL) ? r_acc[W-1:0] : r_mc;
    assign o_rsp.rem  = r_acc[W-1:0];

endmodule

### rtl/dlph_seq.sv
module dlph_seq
    import dlph_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_base,
    input  logic [W-1:0] i_target,
    input  logic [W-1:0] i_modulus,
    input  logic         i_out_free,
    input  t_alu_rsp     i_rsp,
    output t_alu_req     o_req,
    output logic         o_idle,
    output t_result      o_res
);

    t_state r_state, n_state;
    t_state r_ret, n_ret;
    logic   r_wait, n_wait;
    logic   r_found, n_found;
    logic [W-1:0] r_p, n_p, r_a, n_a, r_b, n_b, r_ainv, n_ainv, r_n, n_n;
    logic [W-1:0] r_m, n_m, r_d, n_d, r_x, n_x, r_q, n_q, r_e, n_e, r_qe, n_qe;
    logic [W-1:0] r_xi, n_xi, r_g, n_g, r_k, n_k, r_qk, n_qk, r_qk1, n_qk1;
    logic [W-1:0] r_t, n_t, r_h, n_h, r_cur, n_cur, r_j, n_j, r_gg, n_gg;
    logic [W-1:0] r_pr, n_pr, r_pb, n_pb, r_pe, n_pe, r_pm, n_pm;
    logic [W:0]   sum;
    t_alu_req     req;

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_found = r_found;
        n_p = r_p; n_a = r_a; n_b = r_b; n_ainv = r_ainv; n_n = r_n;
        n_m = r_m; n_d = r_d; n_x = r_x; n_q = r_q; n_e = r_e; n_qe = r_qe;
        n_xi = r_xi; n_g = r_g; n_k = r_k; n_qk = r_qk; n_qk1 = r_qk1;
        n_t = r_t; n_h = r_h; n_cur = r_cur; n_j = r_j; n_gg = r_gg;
        n_pr = r_pr; n_pb = r_pb; n_pe = r_pe; n_pm = r_pm;
        req = '{start: 1'b0, op: ALU_MUL, a: '0, b: '0, m: '0};
        sum = {1'b0, r_x} + {1'b0, i_rsp.res};
        o_res = '{valid: 1'b0, exponent: r_x, found: r_found};
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_p = i_modulus;
                    n_a = i_base;
                    n_b = i_target;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_x = '0;
                n_found = 1'b0;
                n_state = (r_p < W'(3)) ? S_DONE : S_RA;
            end
            S_RA: begin
                req = '{start: !r_wait, op: ALU_DIV, a: r_a, b: r_p, m: '0};
                if (i_rsp.done) begin
                    n_a = i_rsp.rem;
                    n_state = S_RB;
                end
            end
            S_RB: begin
                req = '{start: !r_wait, op: ALU_DIV, a: r_b, b: r_p, m: '0};
                if (i_rsp.done) begin
                    n_b = i_rsp.rem;
                    n_state = S_INV;
                end
            end
            S_INV: begin
                n_n = r_p - W'(1);
                n_m = r_p - W'(1);
                n_d = W'(2);
                n_pr = W'(1); n_pb = r_a; n_pe = r_p - W'(2); n_pm = r_p;
                n_ret = S_INV_R;
                n_state = S_PW_LOOP;
            end
            S_INV_R: begin
                n_ainv = r_pr;
                n_state = S_FT;
            end
            S_FT: begin
                if (r_m <= W'(1)) begin
                    n_found = 1'b1;
                    n_state = S_DONE;
                end else begin
                    req = '{start: !r_wait, op: ALU_DIV, a: r_m, b: r_d, m: '0};
                    if (i_rsp.done) begin
                        n_t = i_rsp.res;
                        n_h = i_rsp.rem;
                        n_state = S_FT2;
                    end
                end
            end
            S_FT2: begin
                if (r_t < r_d) begin
                    n_d = r_m;
                    n_state = S_FACT;
                end else if (r_h != '0) begin
                    n_d = r_d + W'(1);
                    n_state = S_FT;
                end else begin
                    n_state = S_FACT;
                end
            end
            S_FACT: begin
                n_q = r_d;
                n_e = '0;
                n_qe = W'(1);
                n_state = S_FD;
            end
            S_FD: begin
                req = '{start: !r_wait, op: ALU_DIV, a: r_m, b: r_q, m: '0};
                if (i_rsp.done) begin
                    if (i_rsp.rem == '0) begin
                        n_m = i_rsp.res;
                        n_e = r_e + W'(1);
                        n_state = S_FQ;
                    end else begin
                        n_state = S_SQ;
                    end
                end
            end
            S_FQ: begin
                req = '{start: !r_wait, op: ALU_MUL, a: r_qe, b: r_q, m: MOD_WORD};
                if (i_rsp.done) begin
                    n_qe = i_rsp.res;
                    n_state = S_FD;
                end
            end
            S_SQ: begin
                req = '{start: !r_wait, op: ALU_DIV, a: r_n, b: r_q, m: '0};
                if (i_rsp.done) begin
                    n_t = i_rsp.res;
                    n_state = S_SG;
                end
            end
            S_SG: begin
                n_pr = W'(1); n_pb = r_a; n_pe = r_t; n_pm = r_p;
                n_ret = S_SG_R;
                n_state = S_PW_LOOP;
            end
            S_SG_R: begin
                n_g = r_pr;
                n_xi = '0;
                n_qk = W'(1);
                n_qk1 = r_q;
                n_k = '0;
                n_state = S_DK;
            end
            S_DK: begin
                if (r_k == r_e) begin
                    n_state = S_CG;
                end else begin
                    n_pr = W'(1); n_pb = r_ainv; n_pe = r_xi; n_pm = r_p;
                    n_ret = S_DK1;
                    n_state = S_PW_LOOP;
                end
            end
            S_DK1: begin
                req = '{start: !r_wait, op: ALU_MUL, a: r_b, b: r_pr, m: {1'b0, r_p}};
                if (i_rsp.done) begin
                    n_t = i_rsp.res;
                    n_state = S_DK2;
                end
            end
            S_DK2: begin
                req = '{start: !r_wait, op: ALU_DIV, a: r_n, b: r_qk1, m: '0};
                if (i_rsp.done) begin
                    n_h = i_rsp.res;
                    n_state = S_DK3;
                end
            end
            S_DK3: begin
                n_pr = W'(1); n_pb = r_t; n_pe = r_h; n_pm = r_p;
                n_ret = S_DK4;
                n_state = S_PW_LOOP;
            end
            S_DK4: begin
                n_h = r_pr;
                n_cur = W'(1);
                n_j = '0;
                n_state = S_SR;
            end
            S_SR: begin
                n_state = (r_h == r_cur) ? S_DG : S_SM;
            end
            S_SM: begin
                req = '{start: !r_wait, op: ALU_MUL, a: r_cur, b: r_g, m: {1'b0, r_p}};
                if (i_rsp.done) begin
                    n_cur = i_rsp.res;
                    n_j = r_j + W'(1);
                    n_state = S_SC;
                end
            end
            S_SC: begin
                if (r_cur == W'(1) || r_j == r_q) begin
                    n_x = '0;
                    n_found = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_state = S_SR;
                end
            end
            S_DG: begin
                req = '{start: !r_wait, op: ALU_MUL, a: r_j, b: r_qk, m: MOD_WORD};
                if (i_rsp.done) begin
                    n_xi = r_xi + i_rsp.res;
                    n_state = S_DG2;
                end
            end
            S_DG2: begin
                req = '{start: !r_wait, op: ALU_MUL, a: r_qk, b: r_q, m: MOD_WORD};
                if (i_rsp.done) begin
                    n_qk = i_rsp.res;
                    n_state = S_DG3;
                end
            end
            S_DG3: begin
                req = '{start: !r_wait, op: ALU_MUL, a: r_qk1, b: r_q, m: MOD_WORD};
                if (i_rsp.done) begin
                    n_qk1 = i_rsp.res;
                    n_k = r_k + W'(1);
                    n_state = S_DK;
                end
            end
            S_CG: begin
                req = '{start: !r_wait, op: ALU_DIV, a: r_n, b: r_qe, m: '0};
                if (i_rsp.done) begin
                    n_gg = i_rsp.res;
                    n_state = S_CG2;
                end
            end
            S_CG2: begin
                req = '{start: !r_wait, op: ALU_DIV, a: r_gg, b: r_qe, m: '0};
                if (i_rsp.done) begin
                    n_t = i_rsp.rem;
                    n_state = S_CG3;
                end
            end
            S_CG3: begin
                req = '{start: !r_wait, op: ALU_DIV, a: r_qe, b: r_q, m: '0};
                if (i_rsp.done) begin
                    n_h = r_qe - i_rsp.res - W'(1);
                    n_state = S_CG4;
                end
            end
            S_CG4: begin
                n_pr = W'(1); n_pb = r_t; n_pe = r_h; n_pm = r_qe;
                n_ret = S_CG5;
                n_state = S_PW_LOOP;
            end
            S_CG5: begin
                req = '{start: !r_wait, op: ALU_MUL, a: r_xi, b: r_gg, m: {1'b0, r_n}};
                if (i_rsp.done) begin
                    n_t = i_rsp.res;
                    n_state = S_CG6;
                end
            end
            S_CG6: begin
                req = '{start: !r_wait, op: ALU_MUL, a: r_t, b: r_pr, m: {1'b0, r_n}};
                if (i_rsp.done) begin
                    n_x = (sum >= {1'b0, r_n}) ? W'(sum - {1'b0, r_n}) : sum[W-1:0];
                    n_d = r_d + W'(1);
                    n_state = S_FT;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_res.valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_PW_LOOP: begin
                if (r_pe == '0) begin
                    n_state = r_ret;
                end else if (r_pe[0]) begin
                    n_state = S_PW_MULR;
                end else begin
                    n_state = S_PW_SQR;
                end
            end
            S_PW_MULR: begin
                req = '{start: !r_wait, op: ALU_MUL, a: r_pr, b: r_pb, m: {1'b0, r_pm}};
                if (i_rsp.done) begin
                    n_pr = i_rsp.res;
                    n_state = S_PW_SQR;
                end
            end
            S_PW_SQR: begin
                req = '{start: !r_wait, op: ALU_MUL, a: r_pb, b: r_pb, m: {1'b0, r_pm}};
                if (i_rsp.done) begin
                    n_pb = i_rsp.res;
                    n_pe = r_pe >> 1;
                    n_state = S_PW_LOOP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_wait = req.start ? 1'b1 : (i_rsp.done ? 1'b0 : r_wait);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wait  <= n_wait;
        end
        r_ret <= n_ret; r_found <= n_found;
        r_p <= n_p; r_a <= n_a; r_b <= n_b; r_ainv <= n_ainv; r_n <= n_n;
        r_m <= n_m; r_d <= n_d; r_x <= n_x; r_q <= n_q; r_e <= n_e; r_qe <= n_qe;
        r_xi <= n_xi; r_g <= n_g; r_k <= n_k; r_qk <= n_qk; r_qk1 <= n_qk1;
        r_t <= n_t; r_h <= n_h; r_cur <= n_cur; r_j <= n_j; r_gg <= n_gg;
        r_pr <= n_pr; r_pb <= n_pb; r_pe <= n_pe; r_pm <= n_pm;
    end

    assign o_req  = req;
    assign o_idle = (r_state == S_IDLE);

endmodule

### rtl/discrete_log_pohlig_hellman_top.sv
// Solves base^x = target modulo a prime modulus by Pohlig-Hellman: modulus-1 is factored by
// trial division, each prime power's digits are found by a search over powers of the
// subgroup generator, and the pieces are joined by the Chinese remainder theorem. All
// arithmetic runs on one shared unit that does a modular multiply or a divide one bit per
// cycle; each operation is loaded from its request, runs 32 bit steps and then returns
// its result with a done strobe. An item needs a series of multiplies and divides:
// up to about 64 for the inverse of base, one divide per trial divisor up to the square
// root of the remaining cofactor, and per digit up to about 64 for the two exponentiations,
// whose exponents together span about the width of the modulus, plus one multiply per
// candidate up to the prime factor. Totals are data-dependent: a modulus below three is
// reported unsolved without a search, while large prime factors make the candidate search
// dominate. The input is not ready while an item is in work; a finished result waits
// in the output register and the next item is accepted meanwhile.
module discrete_log_pohlig_hellman_top
    import dlph_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // base, target, modulus
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // exponent
    output logic        m_axis_tuser    // found
);

    t_alu_req     alu_req;
    t_alu_rsp     alu_rsp;
    t_result      res;
    logic         seq_idle;
    logic         out_free;
    logic         r_ovalid;
    logic [W-1:0] r_oexp;
    logic         r_ofound;

    assign out_free      = !r_ovalid || m_axis_tready;
    assign s_axis_tready = seq_idle;

    dlph_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

    dlph_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_axis_tvalid && seq_idle),
        .i_base     (s_axis_tdata[W-1:0]),
        .i_target   (s_axis_tdata[32+W-1:32]),
        .i_modulus  (s_axis_tdata[64+W-1:64]),
        .i_out_free (out_free),
        .i_rsp      (alu_rsp),
        .o_req      (alu_req),
        .o_idle     (seq_idle),
        .o_res      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res.valid) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
        if (res.valid) begin
            r_oexp   <= res.exponent;
            r_ofound <= res.found;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = 32'(r_oexp);
    assign m_axis_tuser  = r_ofound;

endmodule

### rtl/dlph_checker.sv
module dlph_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output item changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after an item was accepted");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 32'd0)
        else $error("exponent not zero for an unsolved item");

endmodule

bind discrete_log_pohlig_hellman_top dlph_checker u_dlph_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
